// ===== design/mgs_pkg.sv =====
`default_nettype none
package mgs_pkg;

  localparam int POS_W   = 16;
  localparam int STEP_W  = 15;
  localparam int INV_W   = 16;
  localparam int RAND_W  = 16;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_SIGMA_SQ = 2'd2;

  localparam logic signed [POS_W-1:0] START_POSITION_RESET   = 16'sd0;
  localparam logic [STEP_W-1:0]       STEP_SIZE_RESET        = 15'd4096;
  localparam logic [INV_W-1:0]        INV_TWO_SIGMA_SQ_RESET = 16'd2048;

  // exp(-1/16) in Q0.32
  localparam logic [63:0] EXP_RATIO_Q32 = 64'd4034748382;

  // entries past this point of the recurrence all round to zero
  localparam int ROM_DEPTH = 256;
  localparam int ROM_IDX_W = $clog2(ROM_DEPTH);

  typedef logic [ROM_DEPTH-1:0][15:0] exp_rom_t;

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    logic [63:0] v;
    logic [63:0] e;
    v = 64'd1 << 32;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      e = (64'd65535 * v + (64'd1 << 31)) >> 32;
      rom[k] = e[15:0];
      v = (v * EXP_RATIO_Q32 + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  typedef struct packed {
    logic              restart;
    logic [RAND_W-1:0] step_random;
    logic [RAND_W-1:0] accept_random;
  } request_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    accepted;
    logic [COUNT_W-1:0]      accept_total;
  } result_t;

endpackage
`default_nettype wire

// ===== design/mgs_req_if.sv =====
`default_nettype none
interface mgs_req_if
  import mgs_pkg::*;
();
  logic     valid;
  logic     ready;
  request_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/mgs_res_if.sv =====
`default_nettype none
interface mgs_res_if
  import mgs_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/metropolis_gaussian_step_unit.sv =====
// Metropolis step unit for a zero-mean Gaussian target, positions in signed Q4.12.
// request: one item per step with restart, step_random and accept_random.
// result: one item per request with the new position, the accept flag and the
// saturating count of accepted moves since the last restart.
// Configuration writes (start_position, step_size, inv_two_sigma_sq) go through
// cfg_write/cfg_index/cfg_data; unknown indexes are ignored. The user must make
// them only while the unit is idle; the unit itself does not enforce this. One
// 32x16 multiplier is shared by all products under a small sequencer: proposal
// offset, pos^2, trial^2 and the exp argument, one product per cycle. A restart
// item goes from IDLE straight to DONE; a step runs through OFF, TRIAL, TSQ and
// CMP, then to DONE if it moves closer to zero, else through D and LOOK to DONE.
// A new request is taken in the cycle its result appears. A finished result sits
// in an output register; the next request is accepted while it waits, and the
// sequencer holds its last step only when the register is still full at the time
// a second result is ready. Reset loads the configuration defaults, clears
// position and count and empties the output register.
`default_nettype none
module metropolis_gaussian_step_unit
  import mgs_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  mgs_req_if.sink                   request,
  mgs_res_if.source                 result
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_OFF   = 3'd1;
  localparam logic [2:0] ST_TRIAL = 3'd2;
  localparam logic [2:0] ST_TSQ   = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_D     = 3'd5;
  localparam logic [2:0] ST_LOOK  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state;

  logic signed [POS_W-1:0] start_position;
  logic [STEP_W-1:0]       step_size;
  logic [INV_W-1:0]        inv_two_sigma_sq;

  logic signed [POS_W-1:0] current_position;
  logic [COUNT_W-1:0]      accept_count;

  logic              restart;
  logic [RAND_W-1:0] step_random;
  logic [RAND_W-1:0] accept_random;
  logic signed [POS_W-1:0] trial;
  logic [31:0]       psq;
  logic [31:0]       diff;
  logic              acc;

  logic [47:0] prod;
  logic [31:0] mul_a;
  logic [15:0] mul_b;

  logic    out_valid;
  result_t out_data;

  logic signed [17:0] offset;
  logic signed [17:0] trial_wide;
  logic signed [POS_W-1:0] trial_sat;
  logic [POS_W-1:0] pos_abs;
  logic [POS_W-1:0] trial_abs;
  logic [15:0] exp_index;
  logic [15:0] threshold;
  logic        out_free;

  assign request.ready = (state == ST_IDLE);
  assign result.valid  = out_valid;
  assign result.data   = out_data;
  assign out_free      = !out_valid || result.ready;

  assign pos_abs   = current_position[POS_W-1] ? 16'(-current_position) : current_position;
  assign trial_abs = trial[POS_W-1] ? 16'(-trial) : trial;

  // offset = (2*step*u1 >> 16) - step, then saturate the trial
  always_comb begin
    offset     = $signed({2'b00, prod[31:16]}) - $signed({3'b000, step_size});
    trial_wide = 18'(current_position) + offset;
    if (trial_wide > 18'sd32767) begin
      trial_sat = 16'sh7FFF;
    end else if (trial_wide < -18'sd32768) begin
      trial_sat = 16'sh8000;
    end else begin
      trial_sat = trial_wide[POS_W-1:0];
    end
  end

  // indexes past the table give zero; entries past the rom are zero as well
  always_comb begin
    exp_index = prod[47:32];
    if (32'(exp_index) < EXP_TABLE_DEPTH && 32'(exp_index) < ROM_DEPTH) begin
      threshold = EXP_ROM[exp_index[ROM_IDX_W-1:0]];
    end else begin
      threshold = 16'd0;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 16'd0;
    case (state)
      ST_OFF: begin
        mul_a = {16'd0, step_size, 1'b0};
        mul_b = step_random;
      end
      ST_TRIAL: begin
        mul_a = {16'd0, pos_abs};
        mul_b = pos_abs;
      end
      ST_TSQ: begin
        mul_a = {16'd0, trial_abs};
        mul_b = trial_abs;
      end
      ST_D: begin
        mul_a = diff;
        mul_b = inv_two_sigma_sq;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position   <= START_POSITION_RESET;
      step_size        <= STEP_SIZE_RESET;
      inv_two_sigma_sq <= INV_TWO_SIGMA_SQ_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_POSITION:   start_position   <= cfg_data;
        REG_STEP_SIZE:        step_size        <= cfg_data[STEP_W-1:0];
        REG_INV_TWO_SIGMA_SQ: inv_two_sigma_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      current_position <= '0;
      accept_count     <= '0;
      out_valid        <= 1'b0;
      acc              <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (request.valid) begin
            restart       <= request.data.restart;
            step_random   <= request.data.step_random;
            accept_random <= request.data.accept_random;
            acc           <= 1'b0;
            state         <= request.data.restart ? ST_DONE : ST_OFF;
          end
        end
        ST_OFF: begin
          state <= ST_TRIAL;
        end
        ST_TRIAL: begin
          trial <= trial_sat;
          state <= ST_TSQ;
        end
        ST_TSQ: begin
          psq   <= prod[31:0];
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (prod[31:0] <= psq) begin
            acc   <= 1'b1;
            state <= ST_DONE;
          end else begin
            diff  <= prod[31:0] - psq;
            state <= ST_D;
          end
        end
        ST_D: begin
          state <= ST_LOOK;
        end
        ST_LOOK: begin
          acc   <= (accept_random < threshold);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (restart) begin
              current_position      <= start_position;
              accept_count          <= '0;
              out_data.position     <= start_position;
              out_data.accepted     <= 1'b0;
              out_data.accept_total <= '0;
            end else if (acc) begin
              current_position      <= trial;
              out_data.position     <= trial;
              out_data.accepted     <= 1'b1;
              if (accept_count != '1) begin
                accept_count          <= accept_count + 1'b1;
                out_data.accept_total <= accept_count + 1'b1;
              end else begin
                out_data.accept_total <= accept_count;
              end
            end else begin
              out_data.position     <= current_position;
              out_data.accepted     <= 1'b0;
              out_data.accept_total <= accept_count;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== bench/metropolis_gaussian_step_unit_tb.sv =====
`timescale 1ns / 100ps
module metropolis_gaussian_step_unit_tb;
  import mgs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int EXP_DEPTH = 256;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 165;

  // tracks the chain position and accept count, holds predicted results in order
  class chain_tracker;
    logic signed [POS_W-1:0] start_pos;
    logic [STEP_W-1:0]       step;
    logic [INV_W-1:0]        inv;
    logic signed [POS_W-1:0] pos;
    logic [COUNT_W-1:0]      count;
    logic [15:0]             exp_thr [EXP_DEPTH];
    result_t                 predicted_results [$];
    int                      errors;

    function new();
      logic [63:0] v;
      v = 64'd1 << 32;
      for (int k = 0; k < EXP_DEPTH; k++) begin
        exp_thr[k] = 16'((64'd65535 * v + (64'd1 << 31)) >> 32);
        v = (v * 64'd4034748382 + (64'd1 << 31)) >> 32;
      end
      start_pos = START_POSITION_RESET;
      step = STEP_SIZE_RESET;
      inv = INV_TWO_SIGMA_SQ_RESET;
      pos = '0;
      count = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_START_POSITION:   start_pos = val;
        REG_STEP_SIZE:        step = val[STEP_W-1:0];
        REG_INV_TWO_SIGMA_SQ: inv = val;
        default: ;
      endcase
    endfunction

    // one metropolis step (or restart) per accepted request item
    function void advance_chain(request_t req);
      longint offset, trial, tsq, psq;
      logic [63:0] d, k;
      logic [15:0] thr;
      logic acc;
      result_t r;
      acc = 1'b0;
      if (req.restart) begin
        pos = start_pos;
        count = '0;
      end else begin
        offset = longint'((64'd2 * step * req.step_random) >> 16) - longint'(step);
        trial = longint'(pos) + offset;
        if (trial > 32767) trial = 32767;
        if (trial < -32768) trial = -32768;
        tsq = trial * trial;
        psq = longint'(pos) * longint'(pos);
        if (tsq <= psq) begin
          acc = 1'b1;
        end else begin
          d = 64'(tsq - psq) * 64'(inv);
          k = d >> 32;
          thr = (k < EXP_DEPTH) ? exp_thr[k] : 16'd0;
          acc = (req.accept_random < thr);
        end
        if (acc) begin
          pos = trial[POS_W-1:0];
          if (count != '1) count = count + 1'b1;
        end
      end
      r.position = pos;
      r.accepted = acc;
      r.accept_total = count;
      predicted_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (predicted_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: position %0d accepted %0b total %0d", $time,
                 got.position, got.accepted, got.accept_total);
      end else begin
        want = predicted_results.pop_front();
        if (got.position !== want.position) begin
          errors++;
          $display("%0t position: expected %0d, got %0d", $time, want.position,
                   got.position);
        end
        if (got.accepted !== want.accepted) begin
          errors++;
          $display("%0t accepted: expected %0b, got %0b", $time, want.accepted,
                   got.accepted);
        end
        if (got.accept_total !== want.accept_total) begin
          errors++;
          $display("%0t accept_total: expected %0d, got %0d", $time, want.accept_total,
                   got.accept_total);
        end
      end
    endfunction

    function int pending();
      return predicted_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  bit steady_flow;
  int quiet_cycles;
  chain_tracker tracker;

  mgs_req_if request_ch ();
  mgs_res_if result_ch ();

  metropolis_gaussian_step_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request_ch),
    .result    (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check then pick the next ready value
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) tracker.check_result(result_ch.data);
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= steady_flow || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("metropolis_gaussian_step_unit_tb: errors");
      $finish;
    end
  end

  task automatic send_item(input logic rs, input logic [RAND_W-1:0] u1,
                           input logic [RAND_W-1:0] u2);
    request_t item;
    item.restart = rs;
    item.step_random = u1;
    item.accept_random = u2;
    while (!steady_flow && $urandom_range(99) < 21) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
    request_ch.valid <= 1'b1;
    request_ch.data <= item;
    do @(posedge clk); while (!request_ch.ready);
    tracker.advance_chain(item);
  endtask

  // hold off the sender until every predicted result has come back
  task automatic drain();
    request_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] step_word,
                              input logic [CFG_W-1:0] inv, input bit poke_unused);
    put_reg(REG_START_POSITION, start);
    put_reg(REG_STEP_SIZE, step_word);
    put_reg(REG_INV_TWO_SIGMA_SQ, inv);
    if (poke_unused) put_reg(REG_UNUSED, 16'($urandom));
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] start, step_word, inv;
    logic [RAND_W-1:0] u1;
    tracker = new();
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_START_POSITION;
    cfg_data <= '0;
    request_ch.valid <= 1'b0;
    request_ch.data <= '0;
    steady_flow = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero offset, move away accepted on low u2, move closer, reject
    send_item(1'b0, 16'h8000, 16'h0000);
    send_item(1'b0, 16'h0000, 16'h0000);
    send_item(1'b0, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 16'hFFFF, 16'hFFFF);
    send_item(1'b1, 16'hFFFF, 16'hFFFF);
    drain();

    // widest step, sharpest target: saturation and index past the table end
    write_config(16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_item(1'b1, 16'h0000, 16'h0000);
    send_item(1'b0, 16'hFFFF, 16'h0000);
    send_item(1'b0, 16'h0000, 16'h3039);
    send_item(1'b0, 16'hFFFF, 16'h0000);
    send_item(1'b0, 16'h8000, 16'h5555);
    drain();

    // zero step size always stays put and accepts
    write_config(16'h8000, 16'h0000, 16'h0000, 1'b1);
    send_item(1'b1, 16'hA5A5, 16'h5A5A);
    send_item(1'b0, 16'($urandom), 16'($urandom));
    send_item(1'b0, 16'hFFFF, 16'hFFFF);
    drain();

    // flat target: threshold is the first table entry
    write_config(16'h0000, 16'h0001, 16'h0000, 1'b0);
    send_item(1'b1, 16'h0000, 16'h0000);
    send_item(1'b0, 16'h0000, 16'hFFFF);
    send_item(1'b0, 16'h0000, 16'hFFFE);
    drain();

    write_config(16'h1000, 16'h1000, 16'h1000, 1'b1);
    send_item(1'b1, 16'h0000, 16'h0000);
    send_item(1'b0, 16'h4000, 16'h8000);
    send_item(1'b0, 16'hC000, 16'h7FFF);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(4))
        0: start = 16'h8000;
        1: start = 16'h7FFF;
        default: start = 16'($urandom);
      endcase
      case ($urandom_range(5))
        0: step_word = 16'h0000;
        1: step_word = 16'h7FFF;
        2, 3: step_word = 16'($urandom_range(8192, 64));
        default: step_word = 16'($urandom_range(32767));
      endcase
      step_word[15] = 1'($urandom);
      case ($urandom_range(5))
        0: inv = 16'h0000;
        1: inv = 16'hFFFF;
        2, 3: inv = 16'($urandom_range(4096, 16));
        default: inv = 16'($urandom);
      endcase
      write_config(start, step_word, inv, 1'($urandom_range(1)));
      steady_flow = (ph == 4);
      send_item(1'b1, 16'($urandom), 16'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) == 0) drain();
        case ($urandom_range(9))
          0: u1 = 16'h0000;
          1: u1 = 16'hFFFF;
          default: u1 = 16'($urandom);
        endcase
        send_item($urandom_range(99) < 3, u1, 16'($urandom));
      end
      drain();
    end
    steady_flow = 1'b0;

    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("metropolis_gaussian_step_unit_tb: clean");
    end else begin
      $display("metropolis_gaussian_step_unit_tb: errors");
    end
    $finish;
  end

endmodule
